>>> rtl/core/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_FREE    = 3'd1;
    localparam logic [2:0] CMD_RESIZE  = 3'd2;
    localparam logic [2:0] CMD_QSIZE   = 3'd3;
    localparam logic [2:0] CMD_ONHEAP  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOMEM    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_DALIGN  = 2'd2;

    localparam int unsigned DIVIDEND_W = 34;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DISPATCH,
        OP_FIND_RD,
        OP_FIND_CHK,
        OP_RSZ_NEXT,
        OP_RSZ_MOD,
        OP_GAP_RD,
        OP_GAP_MOD,
        OP_INS_RD,
        OP_INS_WR,
        OP_DEL_RD,
        OP_DEL_WR
    } t_dp_op;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] limit;
        logic [12:0] dalign;
    } t_cfg;

    typedef struct packed {
        logic [2:0] cmd;
        logic       idx_eq_cnt;
        logic       match;
        logic       shrink;
        logic       nospace;
        logic       mod_busy;
        logic       rsz_fit;
        logic       gap_fit;
        logic       ins_at_gap;
        logic       del_end;
    } t_dp_stat;

    typedef struct packed {
        logic [31:0] hdr;
        logic [31:0] size;
    } t_entry;

endpackage

>>> rtl/core/first_fit_block_allocator_top.sv
// First-fit block allocator: configuration registers and controller/datapath wiring.
//
// One command is taken while busy is low; its single result word appears on
// the o_ ports for one cycle with o_valid high and cannot be held off. A lookup
// (free, resize, size query) reads and checks each table entry visited in turn;
// each gap tested by allocate or a moving resize waits on the bit-serial remainder
// unit used for the alignment; insert and remove shift the single-port table one
// entry at a time. The on-heap query and unknown commands go from dispatch
// straight to done. No clearing pass follows reset.
module first_fit_block_allocator_top import ffba_pkg::*; #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_req_size,
    input  logic [12:0] i_req_align,
    input  logic [31:0] i_data_addr,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_addr,
    output logic [31:0] o_block_size,
    output logic        o_on_heap,
    output logic        o_moved
);
    t_cfg     r_cfg;
    t_dp_op   op;
    t_dp_stat stat;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base   <= '0;
            r_cfg.limit  <= '0;
            r_cfg.dalign <= 13'd4;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_BASE:   r_cfg.base   <= pwdata;
                REG_LIMIT:  r_cfg.limit  <= pwdata;
                REG_DALIGN: r_cfg.dalign <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BASE:   prdata = r_cfg.base;
            REG_LIMIT:  prdata = r_cfg.limit;
            REG_DALIGN: prdata = {19'b0, r_cfg.dalign};
            default:    prdata = '0;
        endcase
    end

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_op    (op),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (op),
        .i_cfg         (r_cfg),
        .i_cmd         (i_cmd),
        .i_req_size    (i_req_size),
        .i_req_align   (i_req_align),
        .i_data_addr   (i_data_addr),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_result_addr (o_result_addr),
        .o_block_size  (o_block_size),
        .o_on_heap     (o_on_heap),
        .o_moved       (o_moved)
    );

endmodule

>>> rtl/core/ffba_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module ffba_rem import ffba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [12:0]           i_divisor,
    output logic                  o_busy,
    output logic [12:0]           o_rem
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_q;
    logic [12:0]           r_rem, r_div;
    logic [13:0]           trial;

    assign trial  = {r_rem, r_q[DIVIDEND_W-1]};
    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(DIVIDEND_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (o_busy) begin
            r_q <= {r_q[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= 13'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[12:0];
            end
        end
    end

endmodule

>>> rtl/core/ffba_dp.sv
// Datapath: block table memory, entry count, address arithmetic and result registers.
module ffba_dp import ffba_pkg::*; #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_op      i_op,
    input  t_cfg        i_cfg,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_req_size,
    input  logic [12:0] i_req_align,
    input  logic [31:0] i_data_addr,
    output t_dp_stat    o_stat,
    output logic [1:0]  o_status,
    output logic [31:0] o_result_addr,
    output logic [31:0] o_block_size,
    output logic        o_on_heap,
    output logic        o_moved
);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam logic [35:0] HB   = 36'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    t_entry mem [MAX_BLOCKS];
    t_entry r_rd;

    logic [2:0]    r_cmd;
    logic [31:0]   r_size, r_addr, r_hdr_i, r_newdata;
    logic [12:0]   r_align;
    logic [CW-1:0] r_idx, r_count, r_fi, r_gap;
    logic [35:0]   r_prev_end, r_c;
    logic signed [35:0] r_next;
    logic [1:0]    r_status;
    logic [31:0]   r_result, r_bsize;
    logic          r_onh, r_moved;

    logic [12:0]   align_pick, rem;
    logic          mod_busy, mod_start;
    logic [DIVIDEND_W-1:0] dividend;
    logic signed [35:0] last, next_g;
    logic [35:0]   c_up, end_prev;
    logic          nospace, match, shrink, gap_fit, rsz_fit, ins_at_gap, del_end, idx_eq_cnt;
    logic [CW-1:0] ra, idx_inc;
    logic          we;
    logic [AW-1:0] wa;
    t_entry        wd;

    assign align_pick = (i_req_align != '0) ? i_req_align :
                        (i_cfg.dalign != '0) ? i_cfg.dalign : 13'd1;

    assign mod_start = (i_op == OP_GAP_RD) || (i_op == OP_RSZ_NEXT);
    assign dividend  = (i_op == OP_GAP_RD) ? DIVIDEND_W'(r_prev_end + HB)
                                           : DIVIDEND_W'(r_addr);

    ffba_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (dividend),
        .i_divisor  (r_align),
        .o_busy     (mod_busy),
        .o_rem      (rem)
    );

    assign idx_inc    = r_idx + 1'b1;
    assign idx_eq_cnt = (r_idx == r_count);
    assign last       = $signed({4'b0, i_cfg.limit}) - $signed(HB);
    assign nospace    = (r_count >= MAXC) || (last < 0) || (last == $signed({4'b0, i_cfg.base}));
    assign match      = ({1'b0, r_rd.hdr} + 33'(HEADER_BYTES)) == {1'b0, r_addr};
    assign shrink     = (r_size <= r_rd.size);
    assign next_g     = idx_eq_cnt ? last : $signed({4'b0, r_rd.hdr});
    // round the candidate up to the next multiple of the alignment
    assign c_up       = r_c + ((rem != '0) ? 36'(r_align - rem) : 36'd0);
    assign gap_fit    = $signed(c_up + {4'b0, r_size}) <= next_g;
    assign rsz_fit    = (rem == '0) &&
                        ($signed({4'b0, r_size}) <= r_next - $signed({4'b0, r_addr}));
    assign end_prev   = {4'b0, r_rd.hdr} + HB + {4'b0, r_rd.size};
    assign ins_at_gap = (r_idx == r_gap);
    assign del_end    = (idx_inc >= r_count);

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.idx_eq_cnt = idx_eq_cnt;
        o_stat.match      = match;
        o_stat.shrink     = shrink;
        o_stat.nospace    = nospace;
        o_stat.mod_busy   = mod_busy;
        o_stat.rsz_fit    = rsz_fit;
        o_stat.gap_fit    = gap_fit;
        o_stat.ins_at_gap = ins_at_gap;
        o_stat.del_end    = del_end;
    end

    always_comb begin
        case (i_op)
            OP_INS_RD: ra = r_idx - 1'b1;
            OP_DEL_RD: ra = idx_inc;
            default:   ra = r_idx;
        endcase
    end

    always_comb begin
        we = 1'b0;
        wa = r_idx[AW-1:0];
        wd = r_rd;
        case (i_op)
            OP_FIND_CHK: begin
                if (match && r_cmd == CMD_RESIZE && shrink) begin
                    we = 1'b1;
                    wd = '{hdr: r_rd.hdr, size: r_size};
                end
            end
            OP_RSZ_MOD: begin
                if (!mod_busy && rsz_fit) begin
                    we = 1'b1;
                    wa = r_fi[AW-1:0];
                    wd = '{hdr: r_hdr_i, size: r_size};
                end
            end
            OP_INS_RD: begin
                if (ins_at_gap) begin
                    we = 1'b1;
                    wa = r_gap[AW-1:0];
                    wd = '{hdr: r_newdata - 32'(HEADER_BYTES), size: r_size};
                end
            end
            OP_INS_WR, OP_DEL_WR: we = 1'b1;
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[ra[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_op == OP_INS_RD && ins_at_gap) begin
            r_count <= r_count + 1'b1;
        end else if (i_op == OP_DEL_RD && del_end) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_cmd    <= i_cmd;
                r_size   <= i_req_size;
                r_align  <= align_pick;
                r_addr   <= i_data_addr;
                r_status <= ST_OK;
                r_result <= '0;
                r_bsize  <= '0;
                r_onh    <= 1'b0;
                r_moved  <= 1'b0;
            end
            OP_DISPATCH: begin
                r_idx      <= '0;
                r_prev_end <= {4'b0, i_cfg.base} + HB;
                if (r_cmd == CMD_ONHEAP) begin
                    r_onh <= ({1'b0, r_addr} >= {1'b0, i_cfg.base} + 33'(2 * HEADER_BYTES))
                             && (r_addr < i_cfg.limit);
                end
                if (r_cmd == CMD_ALLOC && nospace) begin
                    r_status <= ST_NOMEM;
                end
            end
            OP_FIND_RD: begin
                if (idx_eq_cnt) begin
                    r_status <= ST_NOTFOUND;
                end
            end
            OP_FIND_CHK: begin
                if (!match) begin
                    r_idx <= idx_inc;
                end else begin
                    r_fi    <= r_idx;
                    r_hdr_i <= r_rd.hdr;
                    if (r_cmd == CMD_QSIZE) begin
                        r_bsize <= r_rd.size;
                    end
                    if (r_cmd == CMD_RESIZE) begin
                        if (shrink) begin
                            r_result <= r_addr;
                        end else begin
                            r_idx <= idx_inc;
                        end
                    end
                end
            end
            OP_RSZ_NEXT: begin
                r_next <= next_g;
            end
            OP_RSZ_MOD: begin
                if (!mod_busy) begin
                    if (rsz_fit) begin
                        r_result <= r_addr;
                    end else if (nospace) begin
                        r_status <= ST_NOMEM;
                    end else begin
                        r_idx      <= '0;
                        r_prev_end <= {4'b0, i_cfg.base} + HB;
                    end
                end
            end
            OP_GAP_RD: begin
                r_c <= r_prev_end + HB;
            end
            OP_GAP_MOD: begin
                if (!mod_busy) begin
                    if (gap_fit) begin
                        r_gap     <= r_idx;
                        r_newdata <= c_up[31:0];
                        r_idx     <= r_count;
                    end else begin
                        r_prev_end <= end_prev;
                        if (idx_eq_cnt) begin
                            r_status <= ST_NOMEM;
                        end else begin
                            r_idx <= idx_inc;
                        end
                    end
                end
            end
            OP_INS_RD: begin
                if (ins_at_gap) begin
                    r_result <= r_newdata;
                    if (r_cmd == CMD_RESIZE) begin
                        r_moved <= 1'b1;
                        // the old block moved up one place if the new one went below it
                        r_idx   <= (r_gap <= r_fi) ? CW'(r_fi + 1'b1) : r_fi;
                    end
                end
            end
            OP_INS_WR: r_idx <= r_idx - 1'b1;
            OP_DEL_WR: r_idx <= idx_inc;
            default: ;
        endcase
    end

    assign o_status      = r_status;
    assign o_result_addr = r_result;
    assign o_block_size  = r_bsize;
    assign o_on_heap     = r_onh;
    assign o_moved       = r_moved;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC)
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
                            || r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

    a_mod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_start |-> !mod_busy)
        else $error("remainder unit restarted while busy");

endmodule

>>> rtl/core/ffba_ctrl.sv
// Controller: sequences table search, gap search, insert and remove per command.
module ffba_ctrl import ffba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy,
    output logic     o_valid
);
    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DISPATCH = 14'b00000000000010,
        S_FIND_RD  = 14'b00000000000100,
        S_FIND_CHK = 14'b00000000001000,
        S_RSZ_RD   = 14'b00000000010000,
        S_RSZ_NEXT = 14'b00000000100000,
        S_RSZ_MOD  = 14'b00000001000000,
        S_GAP_RD   = 14'b00000010000000,
        S_GAP_MOD  = 14'b00000100000000,
        S_INS_RD   = 14'b00001000000000,
        S_INS_WR   = 14'b00010000000000,
        S_DEL_RD   = 14'b00100000000000,
        S_DEL_WR   = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_op = OP_DISPATCH;
                case (i_stat.cmd)
                    CMD_ALLOC:  n_state = i_stat.nospace ? S_DONE : S_GAP_RD;
                    CMD_FREE, CMD_RESIZE, CMD_QSIZE: n_state = S_FIND_RD;
                    default:    n_state = S_DONE;
                endcase
            end
            S_FIND_RD: begin
                o_op    = OP_FIND_RD;
                n_state = i_stat.idx_eq_cnt ? S_DONE : S_FIND_CHK;
            end
            S_FIND_CHK: begin
                o_op = OP_FIND_CHK;
                if (!i_stat.match) begin
                    n_state = S_FIND_RD;
                end else if (i_stat.cmd == CMD_FREE) begin
                    n_state = S_DEL_RD;
                end else if (i_stat.cmd == CMD_RESIZE && !i_stat.shrink) begin
                    n_state = S_RSZ_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RSZ_RD:   n_state = S_RSZ_NEXT;
            S_RSZ_NEXT: begin
                o_op    = OP_RSZ_NEXT;
                n_state = S_RSZ_MOD;
            end
            S_RSZ_MOD: begin
                o_op = OP_RSZ_MOD;
                if (!i_stat.mod_busy) begin
                    n_state = (i_stat.rsz_fit || i_stat.nospace) ? S_DONE : S_GAP_RD;
                end
            end
            S_GAP_RD: begin
                o_op    = OP_GAP_RD;
                n_state = S_GAP_MOD;
            end
            S_GAP_MOD: begin
                o_op = OP_GAP_MOD;
                if (!i_stat.mod_busy) begin
                    if (i_stat.gap_fit) begin
                        n_state = S_INS_RD;
                    end else if (i_stat.idx_eq_cnt) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GAP_RD;
                    end
                end
            end
            S_INS_RD: begin
                o_op = OP_INS_RD;
                if (!i_stat.ins_at_gap) begin
                    n_state = S_INS_WR;
                end else begin
                    n_state = (i_stat.cmd == CMD_RESIZE) ? S_DEL_RD : S_DONE;
                end
            end
            S_INS_WR: begin
                o_op    = OP_INS_WR;
                n_state = S_INS_RD;
            end
            S_DEL_RD: begin
                // read of the entry above is issued here, written down one place next
                o_op    = OP_DEL_RD;
                n_state = i_stat.del_end ? S_DONE : S_DEL_WR;
            end
            S_DEL_WR: begin
                o_op    = OP_DEL_WR;
                n_state = S_DEL_RD;
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("result strobe while idle");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_DISPATCH))
        else $error("accepted word not dispatched");

endmodule
